// ----- src/rctd_pkg.sv -----
// ----------------------------------------------------------------------------
// rctd_pkg: shared types and constants
// Register indexes, reset values and arithmetic constants of the RC tank
// drive and morph ramp core.
// ----------------------------------------------------------------------------
package rctd_pkg;

   // motor command, -255..255
   typedef logic signed [8:0] cmd_type;

   typedef struct packed {
      logic       dir;
      logic [7:0] pwm;
   } side_type;

   // register indexes
   localparam logic [2:0] REG_DRIVE_MODE    = 3'd0;
   localparam logic [2:0] REG_DEADBAND      = 3'd1;
   localparam logic [2:0] REG_MIN_START     = 3'd2;
   localparam logic [2:0] REG_RC_TIMEOUT_MS = 3'd3;
   localparam logic [2:0] REG_MORPH_STEP_MS = 3'd4;

   // register reset values
   localparam logic        DRIVE_MODE_RST    = 1'b0;
   localparam logic [8:0]  DEADBAND_RST      = 9'd40;
   localparam logic [7:0]  MIN_START_RST     = 8'd25;
   localparam logic [15:0] RC_TIMEOUT_MS_RST = 16'd400;
   localparam logic [6:0]  MORPH_STEP_MS_RST = 7'd70;

   localparam logic        DRIVE_ARCADE = 1'b0;

   localparam logic        FUNC_FRAME = 1'b0;
   localparam logic        FUNC_TICK  = 1'b1;

   // channel arithmetic
   localparam logic signed [16:0] CHAN_CENTER     = 17'sd1500;
   localparam logic signed [10:0] CHAN_LIMIT      = 11'sd500;
   localparam logic signed [9:0]  CMD_OFFSET      = 10'sd255;
   localparam logic signed [9:0]  CMD_MAX         = 10'sd255;
   // x*510/1000 == (x*267387) >> 19 for x in 0..1000
   localparam logic [28:0]        SCALE_MUL       = 29'd267387;
   localparam int                 SCALE_SHIFT     = 19;

   localparam logic [7:0]  PWM_STOP   = 8'd255;
   localparam logic [15:0] TICK_MAX   = 16'hFFFF;

   // morph ramp and servo trims
   localparam logic [15:0] MORPH_SWITCH = 16'd1500;
   localparam logic [6:0]  MORPH_GOAL_HIGH = 7'd90;
   localparam logic [8:0]  SERVO_MAX    = 9'd180;
   localparam logic [8:0]  TRIM_FL      = 9'd7;
   localparam logic [8:0]  TRIM_FR      = 9'd190;
   localparam logic [8:0]  TRIM_BR      = 9'd25;
   localparam logic [8:0]  TRIM_BL      = 9'd180;

endpackage

// ----- src/rc_tank_drive_and_morph_ramp_core.sv -----
// ----------------------------------------------------------------------------
// rc_tank_drive_and_morph_ramp_core: RC tank drive with morph ramp
// Mixes RC frames into two motor sides and ramps a morph position on ticks.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one item per handshake, req_func selects an RC frame or a 1 ms
//            tick; steer, throttle and morph pulse widths ride along.
//   rsp_*  : one result item per request item: direction bits, inverted PWM
//            duties, four servo angles and the failsafe flag.
//   csr_*  : register writes (drive mode, deadband, min start, RC timeout,
//            morph step), always ready; the user must write them only while
//            the core is idle, as the core itself does not enforce it.
// The input register takes each item; channel scaling, mixing and ramp logic
// then load the state and result registers, one item per cycle without stalls.
// When the receiver stalls, the result register holds and the input register
// still takes one more item; req_ready drops only when both are full.
// Synchronous reset clears both stages, stops the motors (PWM 255), parks
// the morph position at 0 and loads the register defaults.
// ----------------------------------------------------------------------------
module rc_tank_drive_and_morph_ramp_core
   import rctd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [15:0] req_steer_raw,
   input  logic [15:0] req_throttle_raw,
   input  logic [15:0] req_morph_raw,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_left_dir_high,
   output logic [7:0]  rsp_left_pwm,
   output logic        rsp_right_dir_high,
   output logic [7:0]  rsp_right_pwm,
   output logic [7:0]  rsp_servo_front_left,
   output logic [7:0]  rsp_servo_front_right,
   output logic [7:0]  rsp_servo_back_right,
   output logic [7:0]  rsp_servo_back_left,
   output logic        rsp_failsafe_on,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   // configuration
   logic        drive_mode_ff;
   logic [8:0]  deadband_ff;
   logic [7:0]  min_start_ff;
   logic [15:0] rc_timeout_ff;
   logic [6:0]  morph_step_ff;

   // input stage
   logic        in_valid_ff, in_valid_in;
   logic        in_func_ff;
   logic [15:0] in_steer_ff, in_throttle_ff, in_morph_ff;

   // state and result
   logic        out_valid_ff, out_valid_in;
   side_type    left_ff, left_in;
   side_type    right_ff, right_in;
   logic [6:0]  pos_ff, pos_in;
   logic        goal_high_ff, goal_high_in;
   logic        moving_ff, moving_in;
   logic [15:0] step_ticks_ff, step_ticks_in;
   logic [15:0] silence_ff, silence_in;
   logic        fail_ff, fail_in;

   logic        fire;
   logic        req_take;

   cmd_type     steer_cmd, thr_cmd;
   logic signed [9:0] steer_w, thr_w, lc, rc, lc_cl, rc_cl;
   cmd_type     left_cmd, right_cmd;
   side_type    left_drv, right_drv;
   logic [15:0] step_inc, silence_inc;
   logic        goal_high_req;
   logic [6:0]  goal_pos;
   logic [8:0]  pos_w, fl, fr, br, bl;

   assign fire      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   rctd_chan u_chan_steer (
      .raw      (in_steer_ff),
      .deadband (deadband_ff),
      .cmd      (steer_cmd)
   );

   rctd_chan u_chan_thr (
      .raw      (in_throttle_ff),
      .deadband (deadband_ff),
      .cmd      (thr_cmd)
   );

   function automatic logic signed [9:0] clamp_cmd(input logic signed [9:0] v);
      logic signed [9:0] r;
      if (v > CMD_MAX) begin
         r = CMD_MAX;
      end else if (v < -CMD_MAX) begin
         r = -CMD_MAX;
      end else begin
         r = v;
      end
      return r;
   endfunction

   always_comb begin
      steer_w = {steer_cmd[8], steer_cmd};
      thr_w   = {thr_cmd[8], thr_cmd};
      if (drive_mode_ff == DRIVE_ARCADE) begin
         lc = thr_w + steer_w;
         rc = thr_w - steer_w;
      end else if (steer_cmd != '0) begin
         lc = steer_w;
         rc = -steer_w;
      end else begin
         lc = thr_w;
         rc = thr_w;
      end
      lc_cl     = clamp_cmd(lc);
      rc_cl     = clamp_cmd(rc);
      // left side runs mirrored
      left_cmd  = 9'(-lc_cl);
      right_cmd = 9'(rc_cl);
   end

   rctd_side u_side_left (
      .cmd       (left_cmd),
      .min_start (min_start_ff),
      .dir_prev  (left_ff.dir),
      .side      (left_drv)
   );

   rctd_side u_side_right (
      .cmd       (right_cmd),
      .min_start (min_start_ff),
      .dir_prev  (right_ff.dir),
      .side      (right_drv)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      pos_in       = pos_ff;
      goal_high_in = goal_high_ff;
      moving_in    = moving_ff;
      step_ticks_in = step_ticks_ff;
      silence_in   = silence_ff;
      fail_in      = fail_ff;

      step_inc      = (step_ticks_ff == TICK_MAX) ? step_ticks_ff : step_ticks_ff + 16'd1;
      silence_inc   = (silence_ff == TICK_MAX) ? silence_ff : silence_ff + 16'd1;
      goal_high_req = !(in_morph_ff > MORPH_SWITCH);
      goal_pos      = goal_high_ff ? MORPH_GOAL_HIGH : 7'd0;

      if (rsp_valid && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (fire) begin
         in_valid_in  = 1'b0;
         out_valid_in = 1'b1;
         if (in_func_ff == FUNC_TICK) begin
            step_ticks_in = step_inc;
            silence_in    = silence_inc;
            if (moving_ff && step_inc >= {9'b0, morph_step_ff}) begin
               step_ticks_in = '0;
               if (pos_ff < goal_pos) begin
                  pos_in = pos_ff + 7'd1;
               end else if (pos_ff > goal_pos) begin
                  pos_in = pos_ff - 7'd1;
               end else begin
                  moving_in = 1'b0;
               end
            end
            fail_in = silence_inc > rc_timeout_ff;
            if (fail_in) begin
               left_in.pwm  = PWM_STOP;
               right_in.pwm = PWM_STOP;
            end
         end else begin
            silence_in = '0;
            fail_in    = 1'b0;
            if (goal_high_req != goal_high_ff) begin
               goal_high_in = goal_high_req;
               moving_in    = 1'b1;
            end
            left_in  = left_drv;
            right_in = right_drv;
         end
      end
      if (req_take) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_mode_ff <= DRIVE_MODE_RST;
         deadband_ff   <= DEADBAND_RST;
         min_start_ff  <= MIN_START_RST;
         rc_timeout_ff <= RC_TIMEOUT_MS_RST;
         morph_step_ff <= MORPH_STEP_MS_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_DRIVE_MODE:    drive_mode_ff <= csr_data[0];
            REG_DEADBAND:      deadband_ff   <= csr_data[8:0];
            REG_MIN_START:     min_start_ff  <= csr_data[7:0];
            REG_RC_TIMEOUT_MS: rc_timeout_ff <= csr_data;
            REG_MORPH_STEP_MS: morph_step_ff <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         left_ff       <= '{dir: 1'b0, pwm: PWM_STOP};
         right_ff      <= '{dir: 1'b0, pwm: PWM_STOP};
         pos_ff        <= '0;
         goal_high_ff  <= 1'b0;
         moving_ff     <= 1'b0;
         step_ticks_ff <= '0;
         silence_ff    <= '0;
         fail_ff       <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         left_ff       <= left_in;
         right_ff      <= right_in;
         pos_ff        <= pos_in;
         goal_high_ff  <= goal_high_in;
         moving_ff     <= moving_in;
         step_ticks_ff <= step_ticks_in;
         silence_ff    <= silence_in;
         fail_ff       <= fail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_func_ff     <= req_func;
         in_steer_ff    <= req_steer_raw;
         in_throttle_ff <= req_throttle_raw;
         in_morph_ff    <= req_morph_raw;
      end
   end

   // servo trims off the held position
   always_comb begin
      pos_w = {2'b0, pos_ff};
      fl    = pos_w + TRIM_FL;
      fr    = (pos_w > TRIM_FR) ? '0 : TRIM_FR - pos_w;
      br    = pos_w + TRIM_BR;
      bl    = (pos_w > TRIM_BL) ? '0 : TRIM_BL - pos_w;
      rsp_servo_front_left  = 8'((fl > SERVO_MAX) ? SERVO_MAX : fl);
      rsp_servo_front_right = 8'((fr > SERVO_MAX) ? SERVO_MAX : fr);
      rsp_servo_back_right  = 8'((br > SERVO_MAX) ? SERVO_MAX : br);
      rsp_servo_back_left   = 8'((bl > SERVO_MAX) ? SERVO_MAX : bl);
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_left_dir_high  = left_ff.dir;
   assign rsp_left_pwm       = left_ff.pwm;
   assign rsp_right_dir_high = right_ff.dir;
   assign rsp_right_pwm      = right_ff.pwm;
   assign rsp_failsafe_on    = fail_ff;

endmodule

// ----- src/rctd_chan.sv -----
// ----------------------------------------------------------------------------
// rctd_chan: RC channel to motor command
// Centers a pulse width, applies the deadband, clamps to +/-500 and scales
// to a -255..255 command.
// ----------------------------------------------------------------------------
module rctd_chan
   import rctd_pkg::*;
(
   input  logic [15:0] raw,
   input  logic [8:0]  deadband,
   output cmd_type     cmd
);

   logic signed [16:0] centered;
   logic [16:0]        mag;
   logic signed [10:0] limited;
   logic [9:0]         offset;
   logic [28:0]        prod;
   logic [9:0]         scaled;

   always_comb begin
      centered = $signed({1'b0, raw}) - CHAN_CENTER;
      mag      = centered[16] ? 17'(-centered) : 17'(centered);
      if (mag < {8'b0, deadband}) begin
         limited = '0;
      end else if (centered > 17'(CHAN_LIMIT)) begin
         limited = CHAN_LIMIT;
      end else if (centered < -17'(CHAN_LIMIT)) begin
         limited = -CHAN_LIMIT;
      end else begin
         limited = centered[10:0];
      end
      offset = 10'(limited + CHAN_LIMIT);
      prod   = {19'b0, offset} * SCALE_MUL;
      scaled = 10'(prod >> SCALE_SHIFT);
      cmd    = 9'($signed(scaled) - CMD_OFFSET);
   end

endmodule

// ----- src/rctd_side.sv -----
// ----------------------------------------------------------------------------
// rctd_side: motor side driver
// Turns a command into a held direction bit and an inverted PWM duty with a
// minimum start magnitude.
// ----------------------------------------------------------------------------
module rctd_side
   import rctd_pkg::*;
(
   input  cmd_type    cmd,
   input  logic [7:0] min_start,
   input  logic       dir_prev,
   output side_type   side
);

   logic [7:0] mag;
   logic [7:0] mag_lim;

   always_comb begin
      mag     = cmd[8] ? 8'(-cmd) : 8'(cmd);
      mag_lim = (mag < min_start) ? min_start : mag;
      if (cmd == '0) begin
         // stop, direction held
         side.dir = dir_prev;
         side.pwm = PWM_STOP;
      end else begin
         side.dir = ~cmd[8];
         side.pwm = PWM_STOP - mag_lim;
      end
   end

endmodule

// ----- test/rctd_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rctd_checker: result predictor and scoreboard for the tank drive core
// Watches the request, result and register channels. It keeps its own copy of
// the drive, morph ramp and tick counter state, queues the predicted result
// for every accepted item and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module rctd_checker
   import rctd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_func,
   input  logic [15:0] req_steer_raw,
   input  logic [15:0] req_throttle_raw,
   input  logic [15:0] req_morph_raw,

   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_left_dir_high,
   input  logic [7:0]  rsp_left_pwm,
   input  logic        rsp_right_dir_high,
   input  logic [7:0]  rsp_right_pwm,
   input  logic [7:0]  rsp_servo_front_left,
   input  logic [7:0]  rsp_servo_front_right,
   input  logic [7:0]  rsp_servo_back_right,
   input  logic [7:0]  rsp_servo_back_left,
   input  logic        rsp_failsafe_on,

   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,

   output int          errors,
   output int          pending
);

   typedef struct {
      side_type   left;
      side_type   right;
      logic [7:0] front_left;
      logic [7:0] front_right;
      logic [7:0] back_right;
      logic [7:0] back_left;
      logic       failsafe;
   } motor_servo_type;

   motor_servo_type drive_queue[$];

   // register copies
   logic cfg_mode;
   int   cfg_deadband;
   int   cfg_min_start;
   int   cfg_timeout;
   int   cfg_step;

   // drive and ramp state
   side_type    left_side;
   side_type    right_side;
   int          position;
   int          goal;
   logic        moving;
   logic [15:0] step_count;
   logic [15:0] silence_count;

   initial begin
      errors  = 0;
      pending = 0;
   end

   function automatic int clip(int v, int lo, int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // center, deadband, clamp, then scale to -255..255 with truncation
   function automatic int scale_channel(logic [15:0] raw);
      int v;
      int mag;
      v = raw;
      v = v - 1500;
      mag = (v < 0) ? -v : v;
      if (mag < cfg_deadband) v = 0;
      v = clip(v, -500, 500);
      return ((v + 500) * 510) / 1000 - 255;
   endfunction

   function automatic side_type drive_side(int cmd, side_type prev);
      side_type s;
      int       mag;
      s = prev;
      cmd = clip(cmd, -255, 255);
      if (cmd == 0) begin
         s.pwm = PWM_STOP;  // direction holds
      end else begin
         s.dir = (cmd > 0);
         mag = (cmd < 0) ? -cmd : cmd;
         if (mag < cfg_min_start) mag = cfg_min_start;
         s.pwm = 8'(clip(255 - mag, 0, 255));
      end
      return s;
   endfunction

   task automatic predict_drive(logic func, logic [15:0] steer_raw,
                                logic [15:0] thr_raw, logic [15:0] morph_raw);
      motor_servo_type r;
      int           steer;
      int           thr;
      int           lc;
      int           rc;
      int           new_goal;
      logic         fail;
      fail = 1'b0;
      if (func == FUNC_TICK) begin
         if (step_count != TICK_MAX) step_count = step_count + 16'd1;
         if (silence_count != TICK_MAX) silence_count = silence_count + 16'd1;
         if (moving && step_count >= cfg_step) begin
            step_count = '0;
            if (position < goal) position = position + 1;
            else if (position > goal) position = position - 1;
            else moving = 1'b0;
         end
         if (silence_count > cfg_timeout) begin
            fail = 1'b1;
            left_side.pwm  = PWM_STOP;
            right_side.pwm = PWM_STOP;
         end
      end else begin
         silence_count = '0;
         new_goal = (morph_raw > MORPH_SWITCH) ? 0 : int'(MORPH_GOAL_HIGH);
         if (new_goal != goal) begin
            goal   = new_goal;
            moving = 1'b1;
         end
         steer = scale_channel(steer_raw);
         thr   = scale_channel(thr_raw);
         if (cfg_mode == DRIVE_ARCADE) begin
            lc = thr + steer;
            rc = thr - steer;
         end else if (steer != 0) begin
            lc = steer;
            rc = -steer;
         end else begin
            lc = thr;
            rc = thr;
         end
         lc = clip(lc, -255, 255);
         rc = clip(rc, -255, 255);
         // left motor is mounted mirrored
         left_side  = drive_side(-lc, left_side);
         right_side = drive_side(rc, right_side);
      end
      r.left        = left_side;
      r.right       = right_side;
      r.front_left  = 8'(clip(position + 7, 0, 180));
      r.front_right = 8'(clip(190 - position, 0, 180));
      r.back_right  = 8'(clip(position + 25, 0, 180));
      r.back_left   = 8'(clip(180 - position, 0, 180));
      r.failsafe    = fail;
      drive_queue.push_back(r);
   endtask

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      motor_servo_type want;
      if (reset) begin
         cfg_mode       = DRIVE_MODE_RST;
         cfg_deadband   = DEADBAND_RST;
         cfg_min_start  = MIN_START_RST;
         cfg_timeout    = RC_TIMEOUT_MS_RST;
         cfg_step       = MORPH_STEP_MS_RST;
         left_side      = '{dir: 1'b0, pwm: PWM_STOP};
         right_side     = '{dir: 1'b0, pwm: PWM_STOP};
         position       = 0;
         goal           = 0;
         moving         = 1'b0;
         step_count     = '0;
         silence_count  = '0;
         drive_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_DRIVE_MODE:    cfg_mode      = csr_data[0];
               REG_DEADBAND:      cfg_deadband  = csr_data[8:0];
               REG_MIN_START:     cfg_min_start = csr_data[7:0];
               REG_RC_TIMEOUT_MS: cfg_timeout   = csr_data[15:0];
               REG_MORPH_STEP_MS: cfg_step      = csr_data[6:0];
               default: ;
            endcase
         end
         // compare before queueing: a result never belongs to this edge's item
         if (rsp_valid && rsp_ready) begin
            if (drive_queue.size() == 0) begin
               $error("result item arrived with no prediction waiting");
               errors++;
            end else begin
               want = drive_queue.pop_front();
               check_field("left_dir_high", want.left.dir, rsp_left_dir_high);
               check_field("left_pwm", want.left.pwm, rsp_left_pwm);
               check_field("right_dir_high", want.right.dir, rsp_right_dir_high);
               check_field("right_pwm", want.right.pwm, rsp_right_pwm);
               check_field("servo_front_left", want.front_left, rsp_servo_front_left);
               check_field("servo_front_right", want.front_right,
                           rsp_servo_front_right);
               check_field("servo_back_right", want.back_right, rsp_servo_back_right);
               check_field("servo_back_left", want.back_left, rsp_servo_back_left);
               check_field("failsafe_on", want.failsafe, rsp_failsafe_on);
            end
         end
         if (req_valid && req_ready)
            predict_drive(req_func, req_steer_raw, req_throttle_raw, req_morph_raw);
      end
      pending <= drive_queue.size();
   end

endmodule

// ----- test/rc_tank_drive_and_morph_ramp_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rc_tank_drive_and_morph_ramp_core_tb: stimulus and verdict
// Drives directed frames and ticks, then random frame and tick-burst traffic
// under many register settings and idle mixes, including long result stalls
// and tick runs that trip the failsafe. rctd_checker does the checks.
// ----------------------------------------------------------------------------
module rc_tank_drive_and_morph_ramp_core_tb;
   import rctd_pkg::*;

   localparam int HOLD_CYCLES = 60;
   localparam int DRAIN_LIMIT = 20000;

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic        req_func         = FUNC_FRAME;
   logic [15:0] req_steer_raw    = '0;
   logic [15:0] req_throttle_raw = '0;
   logic [15:0] req_morph_raw    = '0;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic        rsp_left_dir_high;
   logic [7:0]  rsp_left_pwm;
   logic        rsp_right_dir_high;
   logic [7:0]  rsp_right_pwm;
   logic [7:0]  rsp_servo_front_left;
   logic [7:0]  rsp_servo_front_right;
   logic [7:0]  rsp_servo_back_right;
   logic [7:0]  rsp_servo_back_left;
   logic        rsp_failsafe_on;
   logic        csr_valid        = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index        = REG_DRIVE_MODE;
   logic [15:0] csr_data         = '0;

   int errors;
   int pending;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int holds_served  = 0;
   int hold_left     = 0;
   int cur_deadband  = DEADBAND_RST;
   int cur_timeout   = RC_TIMEOUT_MS_RST;
   logic morph_high  = 1'b0;
   int items_sent    = 0;
   int frames_sent   = 0;
   int ticks_sent    = 0;
   int settings_used = 1;

   rc_tank_drive_and_morph_ramp_core dut (.*);

   rctd_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

   // result side: random stalls plus an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         holds_served <= holds_served + 1;
         hold_left    <= HOLD_CYCLES;
         rsp_ready    <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_item(logic func, logic [15:0] steer, logic [15:0] thr,
                            logic [15:0] morph);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= func;
      req_steer_raw    <= steer;
      req_throttle_raw <= thr;
      req_morph_raw    <= morph;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (func == FUNC_TICK) ticks_sent++;
      else frames_sent++;
   endtask

   task automatic send_tick();
      send_item(FUNC_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic write_reg(logic [2:0] idx, int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= 16'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // registers change only with nothing in flight
   task automatic load_config(logic mode, int db, int min_start, int timeout,
                              int step_ms);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      write_reg(REG_DRIVE_MODE, int'(mode));
      write_reg(REG_DEADBAND, db);
      write_reg(REG_MIN_START, min_start);
      write_reg(REG_RC_TIMEOUT_MS, timeout);
      write_reg(REG_MORPH_STEP_MS, step_ms);
      csr_valid <= 1'b0;
      cur_deadband = db;
      cur_timeout  = timeout;
      settings_used++;
   endtask

   function automatic logic [15:0] rand_channel();
      int sel;
      int edge_off;
      sel = $urandom_range(19);
      edge_off = cur_deadband - int'($urandom_range(1));
      if (sel < 2) return 16'($urandom);
      else if (sel == 2) return 16'(1500 + edge_off);
      else if (sel == 3) return 16'(1500 - edge_off);
      else if (sel == 4) return ($urandom_range(1) != 0) ? 16'd1000 : 16'd2000;
      else return 16'($urandom_range(900, 2100));
   endfunction

   function automatic logic [15:0] rand_morph();
      int sel;
      sel = $urandom_range(19);
      if ($urandom_range(99) < 15) morph_high = ~morph_high;
      if (sel == 0) return 16'($urandom);
      else if (sel == 1) return morph_high ? 16'd1501 : 16'd1500;
      else if (morph_high) return 16'($urandom_range(1501, 2100));
      else return 16'($urandom_range(900, 1500));
   endfunction

   // frames mixed with tick bursts, some long enough to trip the failsafe
   task automatic run_random(int count);
      int n;
      int k;
      int burst;
      n = 0;
      while (n < count) begin
         k = $urandom_range(99);
         if (k < 40) begin
            send_item(FUNC_FRAME, rand_channel(), rand_channel(), rand_morph());
            n++;
         end else begin
            if (k < 85 || cur_timeout > 100) burst = $urandom_range(1, 8);
            else burst = cur_timeout + $urandom_range(1, 3);
            repeat (burst) send_tick();
            n += burst;
         end
      end
   endtask

   initial begin
      int phase;
      int drain;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings, arcade mix
      send_item(FUNC_FRAME, 16'd1500, 16'd1500, 16'd1500);
      send_item(FUNC_FRAME, 16'd0, 16'd1500, 16'hFFFF);
      send_item(FUNC_FRAME, 16'hFFFF, 16'd0, 16'd0);
      send_item(FUNC_FRAME, 16'd1500, 16'hFFFF, 16'd1501);
      send_item(FUNC_FRAME, 16'd1500, 16'd0, 16'd1500);
      send_item(FUNC_FRAME, 16'd1540, 16'd1500, 16'd1500);
      send_item(FUNC_FRAME, 16'd1539, 16'd1500, 16'd1500);
      send_item(FUNC_FRAME, 16'd1460, 16'd1500, 16'd1500);
      send_item(FUNC_FRAME, 16'd1461, 16'd1500, 16'd1500);
      send_item(FUNC_FRAME, 16'd1500, 16'd1545, 16'd1500);
      send_item(FUNC_FRAME, 16'd2000, 16'd2000, 16'd1500);
      send_item(FUNC_FRAME, 16'd1500, 16'd1500, 16'd1500);
      send_tick();
      send_tick();
      send_tick();
      send_item(FUNC_FRAME, 16'd1000, 16'd2000, 16'd2000);

      // turn in place, no deadband, full min start, instant failsafe and ramp
      load_config(1'b1, 0, 255, 0, 0);
      send_item(FUNC_FRAME, 16'd1503, 16'd1800, 16'd1000);
      send_item(FUNC_FRAME, 16'd1500, 16'd1200, 16'd1000);
      send_tick();
      send_tick();
      send_item(FUNC_FRAME, 16'd1500, 16'd1500, 16'd2000);
      send_tick();
      send_item(FUNC_FRAME, 16'd0, 16'hFFFF, 16'hFFFF);
      send_tick();

      for (phase = 0; phase < 9; phase++) begin
         if (phase < 3) begin
            send_idle_pct = 36;
            recv_idle_pct = 74;
         end else if (phase < 6) begin
            send_idle_pct = 74;
            recv_idle_pct = 36;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (phase)
            0: load_config(DRIVE_ARCADE, 500, 0, 65535, 1);
            1: load_config(1'b1, 0, 255, 0, 100);
            default:
               load_config(1'($urandom_range(1)),
                           ($urandom_range(3) == 0) ? $urandom_range(0, 500)
                                                    : $urandom_range(0, 80),
                           $urandom_range(0, 255), $urandom_range(0, 40),
                           $urandom_range(0, 5));
         endcase
         if (phase == 1 || phase == 4) hold_requests <= hold_requests + 1;
         run_random(220);
      end

      req_valid <= 1'b0;
      drain = 0;
      @(posedge clock);
      while (pending != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      if (drain >= DRAIN_LIMIT) begin
         $display("Verification failed");
      end else begin
         repeat (10) @(posedge clock);
         $display("Drove %0d items (%0d frames, %0d ticks) under %0d register settings,",
                  items_sent, frames_sent, ticks_sent, settings_used);
         $display("with sender/receiver idle mixes, long result stalls and failsafe trips.");
         if (errors == 0) begin
            $display("Verification passed");
         end else begin
            $display("Verification failed");
         end
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/rctd_pkg.sv
src/rctd_chan.sv
src/rctd_side.sv
src/rc_tank_drive_and_morph_ramp_core.sv
test/rctd_checker.sv
test/rc_tank_drive_and_morph_ramp_core_tb.sv
